/* rtl/pan_tilt_servo_slew_positioner_unit_defines.svh */
// Assertion macros used by the pan/tilt positioner core RTL
`ifndef PAN_TILT_SERVO_SLEW_POSITIONER_UNIT_DEFINES_SVH
`define PAN_TILT_SERVO_SLEW_POSITIONER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PTSSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PTSSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTSSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PTSSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/ptssp_pkg.sv */
// Types and constants of the pan/tilt servo slew positioner
package ptssp_pkg;

  localparam int ANGLE_W  = 16;
  localparam int TICK_W   = 12;
  localparam int FIELD_W  = 12;
  localparam int SLOPE_W  = 16;
  localparam int SUM_W    = ANGLE_W + 1;
  localparam int PROD_W   = SLOPE_W + 1 + ANGLE_W;
  localparam int FRAC_SH  = 20;
  localparam int ACC_W    = PROD_W + 1;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_INC  = 2'd2,
    OP_EASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_PAN_RANGE  = 2'd1,
    ST_TILT_RANGE = 2'd2
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_ANGLE   = 3'd0,
    REG_MAX_ANGLE   = 3'd1,
    REG_DEADZONE    = 3'd2,
    REG_STEP_SIZE   = 3'd3,
    REG_PAN_SLOPE   = 3'd4,
    REG_PAN_OFFSET  = 3'd5,
    REG_TILT_SLOPE  = 3'd6,
    REG_TILT_OFFSET = 3'd7
  } reg_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] min_angle;
    logic signed [ANGLE_W-1:0] max_angle;
    logic [FIELD_W-1:0]        deadzone;
    logic [FIELD_W-1:0]        step_size;
    logic [SLOPE_W-1:0]        pan_slope;
    logic [TICK_W-1:0]         pan_offset;
    logic [SLOPE_W-1:0]        tilt_slope;
    logic [TICK_W-1:0]         tilt_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_angle:   16'sd0,
    max_angle:   16'sd12868,
    deadzone:    12'd123,
    step_size:   12'd21,
    pan_slope:   16'd16640,
    pan_offset:  12'd205,
    tilt_slope:  16'd16640,
    tilt_offset: 12'd205
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pan_angle;
    logic signed [ANGLE_W-1:0] tilt_angle;
    status_e                   status;
    logic                      easing;
  } upd_t;

endpackage

/* rtl/ptssp_if.sv */
// Command and result channel interfaces
interface ptssp_cmd_if;
  logic                                         valid;
  logic                                         ready;
  logic [1:0]                                   op;
  logic signed [ptssp_pkg::ANGLE_W-1:0]         pan_value;
  logic signed [ptssp_pkg::ANGLE_W-1:0]         tilt_value;

  modport source (output valid, op, pan_value, tilt_value, input ready);
  modport sink   (input valid, op, pan_value, tilt_value, output ready);
endinterface

interface ptssp_res_if;
  logic                                         valid;
  logic                                         ready;
  logic [ptssp_pkg::TICK_W-1:0]                 pan_ticks;
  logic [ptssp_pkg::TICK_W-1:0]                 tilt_ticks;
  logic [1:0]                                   status;
  logic                                         easing;
  logic signed [ptssp_pkg::ANGLE_W-1:0]         pan_angle;
  logic signed [ptssp_pkg::ANGLE_W-1:0]         tilt_angle;

  modport source (output valid, pan_ticks, tilt_ticks, status, easing, pan_angle,
                  tilt_angle, input ready);
  modport sink   (input valid, pan_ticks, tilt_ticks, status, easing, pan_angle,
                  tilt_angle, output ready);
endinterface

/* rtl/ptssp_apb_regs.sv */
// APB configuration register file
module ptssp_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel_i,
  input  logic                             penable_i,
  input  logic                             pwrite_i,
  input  logic [ptssp_pkg::PADDR_W-1:0]    paddr_i,
  input  logic [ptssp_pkg::PDATA_W-1:0]    pwdata_i,
  output logic [ptssp_pkg::PDATA_W-1:0]    prdata_o,
  output logic                             pready_o,
  output ptssp_pkg::cfg_t                  cfg_o
);

  ptssp_pkg::cfg_t  cfg_q, cfg_d;
  ptssp_pkg::reg_e  idx;
  logic             wr_en;

  assign idx      = ptssp_pkg::reg_e'(paddr_i[ptssp_pkg::PADDR_W-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ptssp_pkg::REG_MIN_ANGLE:   cfg_d.min_angle   = pwdata_i[ptssp_pkg::ANGLE_W-1:0];
        ptssp_pkg::REG_MAX_ANGLE:   cfg_d.max_angle   = pwdata_i[ptssp_pkg::ANGLE_W-1:0];
        ptssp_pkg::REG_DEADZONE:    cfg_d.deadzone    = pwdata_i[ptssp_pkg::FIELD_W-1:0];
        ptssp_pkg::REG_STEP_SIZE:   cfg_d.step_size   = pwdata_i[ptssp_pkg::FIELD_W-1:0];
        ptssp_pkg::REG_PAN_SLOPE:   cfg_d.pan_slope   = pwdata_i[ptssp_pkg::SLOPE_W-1:0];
        ptssp_pkg::REG_PAN_OFFSET:  cfg_d.pan_offset  = pwdata_i[ptssp_pkg::TICK_W-1:0];
        ptssp_pkg::REG_TILT_SLOPE:  cfg_d.tilt_slope  = pwdata_i[ptssp_pkg::SLOPE_W-1:0];
        ptssp_pkg::REG_TILT_OFFSET: cfg_d.tilt_offset = pwdata_i[ptssp_pkg::TICK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ptssp_pkg::REG_MIN_ANGLE:   prdata_o = ptssp_pkg::PDATA_W'($unsigned(cfg_q.min_angle));
      ptssp_pkg::REG_MAX_ANGLE:   prdata_o = ptssp_pkg::PDATA_W'($unsigned(cfg_q.max_angle));
      ptssp_pkg::REG_DEADZONE:    prdata_o = ptssp_pkg::PDATA_W'(cfg_q.deadzone);
      ptssp_pkg::REG_STEP_SIZE:   prdata_o = ptssp_pkg::PDATA_W'(cfg_q.step_size);
      ptssp_pkg::REG_PAN_SLOPE:   prdata_o = ptssp_pkg::PDATA_W'(cfg_q.pan_slope);
      ptssp_pkg::REG_PAN_OFFSET:  prdata_o = ptssp_pkg::PDATA_W'(cfg_q.pan_offset);
      ptssp_pkg::REG_TILT_SLOPE:  prdata_o = ptssp_pkg::PDATA_W'(cfg_q.tilt_slope);
      ptssp_pkg::REG_TILT_OFFSET: prdata_o = ptssp_pkg::PDATA_W'(cfg_q.tilt_offset);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ptssp_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/ptssp_core.sv */
// Command input register and positioner state update stage
`include "pan_tilt_servo_slew_positioner_unit_defines.svh"

module ptssp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptssp_cmd_if.sink         cmd,
  input  ptssp_pkg::cfg_t   cfg_i,
  output ptssp_pkg::upd_t   upd_o,
  output logic              upd_valid_o,
  input  logic              upd_ready_i
);

  localparam int AW = ptssp_pkg::ANGLE_W;
  localparam int SW = ptssp_pkg::SUM_W;
  localparam int FW = ptssp_pkg::FIELD_W;

  function automatic logic signed [SW-1:0] sx(input logic signed [AW-1:0] v);
    sx = $signed({v[AW-1], v});
  endfunction

  function automatic logic in_lim(input logic signed [SW-1:0] v,
                                  input logic signed [AW-1:0] lo,
                                  input logic signed [AW-1:0] hi);
    in_lim = (v >= sx(lo)) && (v <= sx(hi));
  endfunction

  function automatic ptssp_pkg::status_e chk(input logic signed [SW-1:0] p,
                                             input logic signed [SW-1:0] t,
                                             input logic signed [AW-1:0] lo,
                                             input logic signed [AW-1:0] hi);
    if (!in_lim(p, lo, hi)) begin
      chk = ptssp_pkg::ST_PAN_RANGE;
    end else if (!in_lim(t, lo, hi)) begin
      chk = ptssp_pkg::ST_TILT_RANGE;
    end else begin
      chk = ptssp_pkg::ST_OK;
    end
  endfunction

  // input register
  logic                     a_vld_q;
  ptssp_pkg::op_e           a_op_q;
  logic signed [AW-1:0]     a_pan_q, a_tilt_q;
  logic                     a_fire, a_adv, b_adv;

  // positioner state
  logic                     b_vld_q;
  logic signed [AW-1:0]     cur_pan_q, cur_pan_d, cur_tilt_q, cur_tilt_d;
  logic signed [AW-1:0]     tgt_pan_q, tgt_pan_d, tgt_tilt_q, tgt_tilt_d;
  logic                     dir_pan_q, dir_pan_d, dir_tilt_q, dir_tilt_d;
  logic                     ease_q, ease_d;
  ptssp_pkg::status_e       status_q, status_d;

  logic signed [SW-1:0]     step_x, dz_x, np_tick, nt_tick, np_cmd, nt_cmd;
  logic                     at_p, at_t;
  ptssp_pkg::status_e       st_tick, st_cmd, st_ease;

  assign b_adv     = !b_vld_q || upd_ready_i;
  assign a_fire    = a_vld_q && b_adv;
  assign a_adv     = !a_vld_q || a_fire;
  assign cmd.ready = a_adv;

  assign upd_valid_o      = b_vld_q;
  assign upd_o.pan_angle  = cur_pan_q;
  assign upd_o.tilt_angle = cur_tilt_q;
  assign upd_o.status     = status_q;
  assign upd_o.easing     = ease_q;

  always_comb begin
    step_x = $signed({1'b0, {(SW-FW-1){1'b0}}, cfg_i.step_size});
    dz_x   = $signed({1'b0, {(SW-FW-1){1'b0}}, cfg_i.deadzone});
    at_p   = (sx(cur_pan_q) >= sx(tgt_pan_q) - dz_x) &&
             (sx(cur_pan_q) <= sx(tgt_pan_q) + dz_x);
    at_t   = (sx(cur_tilt_q) >= sx(tgt_tilt_q) - dz_x) &&
             (sx(cur_tilt_q) <= sx(tgt_tilt_q) + dz_x);
    np_tick = sx(cur_pan_q);
    nt_tick = sx(cur_tilt_q);
    if (!at_p) begin
      np_tick = dir_pan_q ? sx(cur_pan_q) + step_x : sx(cur_pan_q) - step_x;
    end
    if (!at_t) begin
      nt_tick = dir_tilt_q ? sx(cur_tilt_q) + step_x : sx(cur_tilt_q) - step_x;
    end
    np_cmd  = (a_op_q == ptssp_pkg::OP_INC) ? sx(cur_pan_q) + sx(a_pan_q) : sx(a_pan_q);
    nt_cmd  = (a_op_q == ptssp_pkg::OP_INC) ? sx(cur_tilt_q) + sx(a_tilt_q) : sx(a_tilt_q);
    st_tick = chk(np_tick, nt_tick, cfg_i.min_angle, cfg_i.max_angle);
    st_cmd  = chk(np_cmd, nt_cmd, cfg_i.min_angle, cfg_i.max_angle);
    st_ease = chk(sx(a_pan_q), sx(a_tilt_q), cfg_i.min_angle, cfg_i.max_angle);
  end

  always_comb begin
    cur_pan_d  = cur_pan_q;
    cur_tilt_d = cur_tilt_q;
    tgt_pan_d  = tgt_pan_q;
    tgt_tilt_d = tgt_tilt_q;
    dir_pan_d  = dir_pan_q;
    dir_tilt_d = dir_tilt_q;
    ease_d     = ease_q;
    status_d   = ptssp_pkg::ST_OK;
    unique case (a_op_q) inside
      ptssp_pkg::OP_TICK: begin
        if (ease_q) begin
          status_d = st_tick;
          if (st_tick == ptssp_pkg::ST_OK) begin
            cur_pan_d  = np_tick[AW-1:0];
            cur_tilt_d = nt_tick[AW-1:0];
          end
          if (st_tick != ptssp_pkg::ST_OK || (at_p && at_t)) begin
            ease_d = 1'b0;
          end
        end
      end
      ptssp_pkg::OP_EASE: begin
        ease_d   = 1'b0;
        status_d = st_ease;
        if (st_ease == ptssp_pkg::ST_OK) begin
          tgt_pan_d  = a_pan_q;
          tgt_tilt_d = a_tilt_q;
          dir_pan_d  = a_pan_q > cur_pan_q;
          dir_tilt_d = a_tilt_q > cur_tilt_q;
          ease_d     = 1'b1;
        end
      end
      ptssp_pkg::OP_SET, ptssp_pkg::OP_INC: begin
        ease_d   = 1'b0;
        status_d = st_cmd;
        if (st_cmd == ptssp_pkg::ST_OK) begin
          cur_pan_d  = np_cmd[AW-1:0];
          cur_tilt_d = nt_cmd[AW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      cur_pan_q  <= '0;
      cur_tilt_q <= '0;
      tgt_pan_q  <= '0;
      tgt_tilt_q <= '0;
      dir_pan_q  <= 1'b0;
      dir_tilt_q <= 1'b0;
      ease_q     <= 1'b0;
    end else begin
      if (a_adv) begin
        a_vld_q <= cmd.valid;
      end
      if (b_adv) begin
        b_vld_q <= a_vld_q;
      end
      if (a_fire) begin
        cur_pan_q  <= cur_pan_d;
        cur_tilt_q <= cur_tilt_d;
        tgt_pan_q  <= tgt_pan_d;
        tgt_tilt_q <= tgt_tilt_d;
        dir_pan_q  <= dir_pan_d;
        dir_tilt_q <= dir_tilt_d;
        ease_q     <= ease_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && cmd.valid) begin
      a_op_q   <= ptssp_pkg::op_e'(cmd.op);
      a_pan_q  <= cmd.pan_value;
      a_tilt_q <= cmd.tilt_value;
    end
    if (a_fire) begin
      status_q <= status_d;
    end
  end

  `PTSSP_ASSERT_NEXT(a_fail_keeps_angles, clk_i, rst_ni,
                     a_fire && status_d != ptssp_pkg::ST_OK,
                     $stable(cur_pan_q) && $stable(cur_tilt_q))
  `PTSSP_ASSERT_NEXT(a_idle_tick_keeps, clk_i, rst_ni,
                     a_fire && a_op_q == ptssp_pkg::OP_TICK && !ease_q,
                     $stable(cur_pan_q) && $stable(cur_tilt_q) && !ease_q)
  `PTSSP_ASSERT_IMPL(a_ease_from_cmd, clk_i, rst_ni, $rose(ease_q),
                     $past(a_fire && a_op_q == ptssp_pkg::OP_EASE))
  `PTSSP_ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, b_vld_q && !upd_ready_i,
                     $stable(cur_pan_q) && $stable(cur_tilt_q) && $stable(ease_q))

endmodule

/* rtl/ptssp_ticks.sv */
// PWM compare value stage and result register
module ptssp_ticks (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptssp_pkg::upd_t   upd_i,
  input  logic              upd_valid_i,
  output logic              upd_ready_o,
  input  ptssp_pkg::cfg_t   cfg_i,
  ptssp_res_if.source       res
);

  localparam int AW  = ptssp_pkg::ANGLE_W;
  localparam int TW  = ptssp_pkg::TICK_W;
  localparam int PW  = ptssp_pkg::PROD_W;
  localparam int CW  = ptssp_pkg::ACC_W;
  localparam int SH  = ptssp_pkg::FRAC_SH;
  localparam int QW  = CW - SH;

  function automatic logic [TW-1:0] to_ticks(input logic signed [AW-1:0] ang,
                                              input logic [ptssp_pkg::SLOPE_W-1:0] slope,
                                              input logic [TW-1:0] offset);
    logic signed [PW-1:0] prod;
    logic signed [CW-1:0] acc;
    logic [QW-1:0]        whole;
    prod  = $signed({1'b0, slope}) * ang;
    acc   = $signed({{(CW-TW-SH){1'b0}}, offset, {SH{1'b0}}}) + $signed({prod[PW-1], prod});
    whole = acc[CW-1:SH];
    if (acc[CW-1]) begin
      to_ticks = '0;
    end else if (|whole[QW-1:TW]) begin
      to_ticks = '1;
    end else begin
      to_ticks = whole[TW-1:0];
    end
  endfunction

  logic out_vld_q, out_adv;

  assign out_adv     = !out_vld_q || res.ready;
  assign upd_ready_o = out_adv;
  assign res.valid   = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= upd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && upd_valid_i) begin
      res.pan_ticks  <= to_ticks(upd_i.pan_angle, cfg_i.pan_slope, cfg_i.pan_offset);
      res.tilt_ticks <= to_ticks(upd_i.tilt_angle, cfg_i.tilt_slope, cfg_i.tilt_offset);
      res.status     <= upd_i.status;
      res.easing     <= upd_i.easing;
      res.pan_angle  <= upd_i.pan_angle;
      res.tilt_angle <= upd_i.tilt_angle;
    end
  end

endmodule

/* rtl/pan_tilt_servo_slew_positioner_unit.sv */
// Top level of the pan/tilt servo slew positioner
//
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      op, pan_value, tilt_value
//   res      out  valid/ready      pan_ticks, tilt_ticks, status, easing,
//                                  pan_angle, tilt_angle
//   apb      in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle sustained while res.ready stays high; a result
// passes the input register, state update and tick register in turn.
// Reset clears the angles, targets, directions and ease flag, and loads the
// register defaults. With res.ready low up to three transactions are held
// in the stages before cmd.ready drops.
module pan_tilt_servo_slew_positioner_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ptssp_cmd_if.sink                      cmd,
  ptssp_res_if.source                    res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ptssp_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptssp_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptssp_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  ptssp_pkg::cfg_t cfg;
  ptssp_pkg::upd_t upd;
  logic            upd_valid, upd_ready;

  ptssp_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  ptssp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd         (cmd),
    .cfg_i       (cfg),
    .upd_o       (upd),
    .upd_valid_o (upd_valid),
    .upd_ready_i (upd_ready)
  );

  ptssp_ticks u_ticks (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .upd_valid_i (upd_valid),
    .upd_ready_o (upd_ready),
    .cfg_i       (cfg),
    .res         (res)
  );

endmodule
